// ===== hdl/sawg_pkg.sv =====
// Shared constants, types and functions of the spiral arc waypoint generator.
`default_nettype none
package sawg_pkg;

    localparam int FRAC_BITS = 16;
    localparam int UP_SHIFT = 30 - FRAC_BITS;
    localparam int DEF_MAX_WAYPOINTS = 64;
    localparam int DEF_CORDIC_ITERATIONS = 16;

    localparam int IN_W = 248;
    localparam int OUT_W = 112;
    localparam int STEP_W = 17;
    localparam int CXW = 60;
    localparam int CZW = 38;

    localparam logic signed [CZW-1:0] Q30_PI = 38'sd3373259426;
    localparam logic signed [CZW-1:0] Q30_TWO_PI = 38'sd6746518852;
    localparam logic signed [CZW-1:0] Q30_HALF_PI = 38'sd1686629713;
    localparam logic signed [CZW-1:0] Q30_YAW_OFFSET = 38'sd3373159940;
    localparam logic signed [CXW-1:0] Q30_GAIN = 60'sd652032874;
    localparam logic [STEP_W-1:0] STEP_RESET = 17'd6554;

    typedef struct packed {
        logic start;
        logic vectoring;
    } t_cordic_ctrl;

    function automatic logic [29:0] atan_q30(input logic [4:0] k);
        case (k)
            5'd0: return 30'd843314857;
            5'd1: return 30'd497837829;
            5'd2: return 30'd263043837;
            5'd3: return 30'd133525159;
            5'd4: return 30'd67021687;
            5'd5: return 30'd33543516;
            5'd6: return 30'd16775851;
            5'd7: return 30'd8388437;
            5'd8: return 30'd4194283;
            5'd9: return 30'd2097149;
            5'd10: return 30'd1048575;
            5'd11: return 30'd524288;
            5'd12: return 30'd262144;
            5'd13: return 30'd131072;
            5'd14: return 30'd65536;
            5'd15: return 30'd32768;
            5'd16: return 30'd16384;
            5'd17: return 30'd8192;
            5'd18: return 30'd4096;
            5'd19: return 30'd2048;
            5'd20: return 30'd1024;
            5'd21: return 30'd512;
            5'd22: return 30'd256;
            5'd23: return 30'd128;
            default: return 30'd0;
        endcase
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        if (v > 40'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -40'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== hdl/sawg_cordic.sv =====
// Shared iterative CORDIC unit, rotation and vectoring modes, one iteration per cycle.
`default_nettype none
module sawg_cordic #(
    parameter int ITERATIONS = sawg_pkg::DEF_CORDIC_ITERATIONS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sawg_pkg::t_cordic_ctrl             i_ctrl,
    input  logic signed [sawg_pkg::CXW-1:0]    i_x,
    input  logic signed [sawg_pkg::CXW-1:0]    i_y,
    input  logic signed [sawg_pkg::CZW-1:0]    i_z,
    output logic signed [sawg_pkg::CXW-1:0]    o_x,
    output logic signed [sawg_pkg::CXW-1:0]    o_y,
    output logic signed [sawg_pkg::CZW-1:0]    o_z,
    output logic                               o_busy
);
    import sawg_pkg::*;

    localparam int KW = $clog2(ITERATIONS);

    logic                  r_busy;
    logic                  r_vect;
    logic [KW-1:0]         r_k;
    logic signed [CXW-1:0] r_x;
    logic signed [CXW-1:0] r_y;
    logic signed [CZW-1:0] r_z;
    logic signed [CXW-1:0] sh_x;
    logic signed [CXW-1:0] sh_y;
    logic signed [CZW-1:0] at;
    logic                  go_neg;

    assign sh_x = r_x >>> r_k;
    assign sh_y = r_y >>> r_k;
    assign at = $signed({{(CZW-30){1'b0}}, atan_q30(5'(r_k))});
    assign go_neg = r_vect ? (r_y > 0) : (r_z < 0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k <= '0;
        end else if (i_ctrl.start) begin
            r_busy <= 1'b1;
            r_k <= '0;
            r_vect <= i_ctrl.vectoring;
            r_x <= i_x;
            r_y <= i_y;
            r_z <= i_z;
        end else if (r_busy) begin
            if (go_neg) begin
                r_x <= r_x + sh_y;
                r_y <= r_y - sh_x;
                r_z <= r_z + at;
            end else begin
                r_x <= r_x - sh_y;
                r_y <= r_y + sh_x;
                r_z <= r_z - at;
            end
            if (r_k == KW'(ITERATIONS - 1)) begin
                r_busy <= 1'b0;
            end
            r_k <= r_k + 1'b1;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
    assign o_busy = r_busy;

endmodule
`default_nettype wire

// ===== hdl/spiral_arc_waypoint_generator.sv =====
// Top level of the spiral arc waypoint generator: sequencer, shared multiplier and datapath.
//
// One input beat on the s_axis channel carries robot position, object center, sweep angle
// and target radius. The block answers with one to MAX_WAYPOINTS beats on the m_axis
// channel, each a waypoint x/y with a heading quaternion; tlast marks the final one.
// i_cfg_we writes the angle step register; write it only while the block is idle.
// s_axis_tready is high only while idle: one request is worked on at a time.
// Setup runs three squares on the shared
// multiplier, a 32-step square root, one vectoring CORDIC pass and a 48-step divider.
// Each waypoint then makes two rotation passes of the shared CORDIC unit,
// plus an angle reduction that removes one turn of angle per step.
// Results pass through an output register, so the next waypoint is computed while one
// waits; the sequencer holds when the receiver stalls and a finished beat is still held.
// Reset returns the block to idle, drops m_axis_tvalid and sets the angle step to 6554.
`default_nettype none
module spiral_arc_waypoint_generator #(
    parameter int MAX_WAYPOINTS = sawg_pkg::DEF_MAX_WAYPOINTS,
    parameter int CORDIC_ITERATIONS = sawg_pkg::DEF_CORDIC_ITERATIONS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sawg_pkg::STEP_W-1:0]     i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // robot_x, robot_y, robot_z, center_x, center_y, center_z, sweep_angle, target_radius
    input  logic [sawg_pkg::IN_W-1:0]       s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // waypoint_x, waypoint_y, heading_quat_z, heading_quat_w, step_index
    output logic [sawg_pkg::OUT_W-1:0]      m_axis_tdata,
    output logic                            m_axis_tlast
);
    import sawg_pkg::*;

    localparam int NW = $clog2(MAX_WAYPOINTS) + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_SQX, S_SQY, S_SQZ, S_SQSUM, S_SQRT, S_ATAN, S_ATAN_WAIT,
        S_DIV_INIT, S_DIV, S_DIV_END, S_WP_MUL, S_WP_RAD, S_RED, S_FOLD, S_HALF,
        S_ROT_WAIT, S_MULC, S_WX, S_WY, S_QUAT, S_EMIT
    } t_state;

    t_state                r_state;
    logic [STEP_W-1:0]     r_angle_step;
    logic [STEP_W-1:0]     r_step;
    logic signed [32:0]    r_dx, r_dy, r_dz;
    logic signed [31:0]    r_cx, r_cy;
    logic [18:0]           r_sweep;
    logic [30:0]           r_target;
    logic [63:0]           r_acc;
    logic [63:0]           r_root;
    logic [5:0]            r_j;
    logic [30:0]           r_start_radius;
    logic signed [19:0]    r_start_angle;
    logic [47:0]           r_quo;
    logic [18:0]           r_rem;
    logic                  r_div_neg;
    logic signed [31:0]    r_rpr;
    logic [19:0]           r_sweep_limit;
    logic [19:0]           r_i;
    logic [NW-1:0]         r_n;
    logic signed [31:0]    r_rad;
    logic signed [CZW-1:0] r_ang30;
    logic signed [CZW-1:0] r_red;
    logic                  r_neg;
    logic                  r_pass;
    logic signed [32:0]    r_sin, r_cos;
    logic signed [31:0]    r_wx, r_wy;
    logic signed [17:0]    r_qz, r_qw;
    logic signed [65:0]    r_prod;
    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_data;
    logic                  r_out_last;

    logic signed [32:0]    mul_a, mul_b;
    logic signed [31:0]    sx, sy, sz;
    logic [63:0]           sq_bit;
    logic [64:0]           sq_try;
    logic [19:0]           rem_sh;
    logic signed [31:0]    diff;
    logic [31:0]           diff_mag;
    logic signed [65:0]    rnd16, rnd30;
    logic signed [21:0]    ang_sum;
    logic signed [CZW-1:0] ang_new;
    logic signed [CZW-1:0] z_half;
    logic signed [CZW-1:0] atan_rnd;
    logic signed [32:0]    q_sin, q_cos;
    logic [20:0]           i_plus;
    logic                  is_last;
    logic                  on_center;
    logic signed [CXW-1:0] vx0, vy0;
    t_cordic_ctrl          cor_ctrl;
    logic signed [CXW-1:0] cor_xi, cor_yi, cor_x, cor_y;
    logic signed [CZW-1:0] cor_zi, cor_z;
    logic                  cor_busy;

    function automatic logic signed [31:0] clamp_diff(input logic signed [32:0] v);
        if (v > 33'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -33'sd2147483647) begin
            return 32'sh80000001;
        end else begin
            return v[31:0];
        end
    endfunction

    function automatic logic signed [17:0] clamp_one(input logic signed [32:0] v);
        logic signed [32:0] r;
        r = (v + (33'sd1 <<< (UP_SHIFT - 1))) >>> UP_SHIFT;
        if (r > (33'sd1 <<< FRAC_BITS)) begin
            return 18'(33'sd1 <<< FRAC_BITS);
        end else if (r < -(33'sd1 <<< FRAC_BITS)) begin
            return 18'(-(33'sd1 <<< FRAC_BITS));
        end else begin
            return r[17:0];
        end
    endfunction

    assign sx = clamp_diff(r_dx);
    assign sy = clamp_diff(r_dy);
    assign sz = clamp_diff(r_dz);

    always_comb begin
        case (r_state)
            S_SQX: begin
                mul_a = 33'(sx);
                mul_b = 33'(sx);
            end
            S_SQY: begin
                mul_a = 33'(sy);
                mul_b = 33'(sy);
            end
            S_SQZ: begin
                mul_a = 33'(sz);
                mul_b = 33'(sz);
            end
            S_WP_MUL: begin
                mul_a = 33'(r_rpr);
                mul_b = $signed({13'd0, r_i});
            end
            S_WX: begin
                mul_a = 33'(r_rad);
                mul_b = r_sin;
            end
            default: begin
                mul_a = 33'(r_rad);
                mul_b = r_cos;
            end
        endcase
    end

    assign sq_bit = 64'd1 << {r_j[4:0], 1'b0};
    assign sq_try = {1'b0, r_root} + {1'b0, sq_bit};
    assign rem_sh = {r_rem, r_quo[47]};
    assign diff = $signed({1'b0, r_target}) - $signed({1'b0, r_start_radius});
    assign diff_mag = diff[31] ? 32'(-diff) : 32'(diff);
    assign rnd16 = (r_prod + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign rnd30 = (r_prod + (66'sd1 <<< 29)) >>> 30;
    assign ang_sum = 22'(r_start_angle) + $signed({2'b00, r_i});
    assign ang_new = 38'(ang_sum) <<< UP_SHIFT;
    assign atan_rnd = (cor_z + (38'sd1 <<< (UP_SHIFT - 1))) >>> UP_SHIFT;
    assign q_sin = r_neg ? 33'(-cor_y) : 33'(cor_y);
    assign q_cos = r_neg ? 33'(-cor_x) : 33'(cor_x);
    assign i_plus = 21'(r_i) + 21'(r_step);
    assign is_last = (r_n == NW'(MAX_WAYPOINTS - 1)) || (i_plus >= 21'(r_sweep_limit));
    assign on_center = (r_dx == 33'sd0) && (r_dy == 33'sd0);

    always_comb begin
        if (r_red > Q30_HALF_PI) begin
            z_half = r_red - Q30_PI;
        end else if (r_red < -Q30_HALF_PI) begin
            z_half = r_red + Q30_PI;
        end else begin
            z_half = r_red;
        end
    end

    assign vx0 = CXW'(r_dx) <<< 24;
    assign vy0 = CXW'(r_dy) <<< 24;

    always_comb begin
        cor_ctrl.start = ((r_state == S_ATAN) && !on_center) || (r_state == S_HALF);
        cor_ctrl.vectoring = (r_state == S_ATAN);
        if (r_state == S_ATAN) begin
            cor_xi = r_dx[32] ? -vx0 : vx0;
            cor_yi = r_dx[32] ? -vy0 : vy0;
            if (r_dx[32]) begin
                cor_zi = r_dy[32] ? -Q30_PI : Q30_PI;
            end else begin
                cor_zi = '0;
            end
        end else begin
            cor_xi = Q30_GAIN;
            cor_yi = '0;
            cor_zi = z_half;
        end
    end

    sawg_cordic #(
        .ITERATIONS(CORDIC_ITERATIONS)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (cor_ctrl),
        .i_x    (cor_xi),
        .i_y    (cor_yi),
        .i_z    (cor_zi),
        .o_x    (cor_x),
        .o_y    (cor_y),
        .o_z    (cor_z),
        .o_busy (cor_busy)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
            r_angle_step <= STEP_RESET;
        end else begin
            if (i_cfg_we) begin
                r_angle_step <= i_cfg_wdata;
            end
            if (m_axis_tready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_dx <= 33'($signed(s_axis_tdata[31:0])) -
                                33'($signed(s_axis_tdata[127:96]));
                        r_dy <= 33'($signed(s_axis_tdata[63:32])) -
                                33'($signed(s_axis_tdata[159:128]));
                        r_dz <= 33'($signed(s_axis_tdata[95:64])) -
                                33'($signed(s_axis_tdata[191:160]));
                        r_cx <= s_axis_tdata[127:96];
                        r_cy <= s_axis_tdata[159:128];
                        r_sweep <= s_axis_tdata[210:192];
                        r_target <= s_axis_tdata[241:211];
                        r_step <= (r_angle_step == '0) ? STEP_W'(1) : r_angle_step;
                        r_state <= S_SQX;
                    end
                end
                S_SQX: r_state <= S_SQY;
                S_SQY: begin
                    r_acc <= r_prod[63:0];
                    r_state <= S_SQZ;
                end
                S_SQZ: begin
                    r_acc <= r_acc + r_prod[63:0];
                    r_state <= S_SQSUM;
                end
                S_SQSUM: begin
                    r_acc <= r_acc + r_prod[63:0];
                    r_root <= '0;
                    r_j <= 6'd31;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if ({1'b0, r_acc} >= sq_try) begin
                        r_acc <= r_acc - sq_try[63:0];
                        r_root <= (r_root >> 1) + sq_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_j <= r_j - 1'b1;
                    if (r_j == 6'd0) begin
                        r_state <= S_ATAN;
                    end
                end
                S_ATAN: begin
                    r_start_radius <= (r_root > 64'd2147483647) ? 31'h7FFFFFFF
                                                                : r_root[30:0];
                    if (on_center) begin
                        r_start_angle <= '0;
                        r_state <= S_DIV_INIT;
                    end else begin
                        r_state <= S_ATAN_WAIT;
                    end
                end
                S_ATAN_WAIT: begin
                    if (!cor_busy) begin
                        r_start_angle <= atan_rnd[19:0];
                        r_state <= S_DIV_INIT;
                    end
                end
                S_DIV_INIT: begin
                    r_rem <= '0;
                    r_div_neg <= diff[31];
                    r_j <= 6'd47;
                    if (r_sweep == '0) begin
                        r_quo <= '0;
                        r_state <= S_DIV_END;
                    end else begin
                        r_quo <= {diff_mag, 16'd0};
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (rem_sh >= {1'b0, r_sweep}) begin
                        r_rem <= 19'(rem_sh - {1'b0, r_sweep});
                        r_quo <= {r_quo[46:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh[18:0];
                        r_quo <= {r_quo[46:0], 1'b0};
                    end
                    r_j <= r_j - 1'b1;
                    if (r_j == 6'd0) begin
                        r_state <= S_DIV_END;
                    end
                end
                S_DIV_END: begin
                    if (r_div_neg) begin
                        r_rpr <= (r_quo > 48'd2147483648) ? 32'sh80000000
                                                          : 32'(-r_quo);
                    end else begin
                        r_rpr <= (r_quo > 48'd2147483647) ? 32'sh7FFFFFFF
                                                          : 32'(r_quo);
                    end
                    r_sweep_limit <= 20'(r_sweep) + 20'(r_step);
                    r_i <= '0;
                    r_n <= '0;
                    r_state <= S_WP_MUL;
                end
                S_WP_MUL: r_state <= S_WP_RAD;
                S_WP_RAD: begin
                    r_rad <= sat32(40'(rnd16) + $signed({9'd0, r_start_radius}));
                    r_ang30 <= ang_new;
                    r_red <= ang_new;
                    r_pass <= 1'b0;
                    r_state <= S_RED;
                end
                S_RED: begin
                    if (r_red >= Q30_TWO_PI) begin
                        r_red <= r_red - Q30_TWO_PI;
                    end else if (r_red <= -Q30_TWO_PI) begin
                        r_red <= r_red + Q30_TWO_PI;
                    end else begin
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    if (r_red > Q30_PI) begin
                        r_red <= r_red - Q30_TWO_PI;
                    end else if (r_red < -Q30_PI) begin
                        r_red <= r_red + Q30_TWO_PI;
                    end
                    r_state <= S_HALF;
                end
                S_HALF: begin
                    r_neg <= (r_red > Q30_HALF_PI) || (r_red < -Q30_HALF_PI);
                    r_state <= S_ROT_WAIT;
                end
                S_ROT_WAIT: begin
                    if (!cor_busy) begin
                        r_sin <= q_sin;
                        r_cos <= q_cos;
                        r_state <= r_pass ? S_QUAT : S_MULC;
                    end
                end
                S_MULC: r_state <= S_WX;
                S_WX: begin
                    r_wx <= sat32(40'(rnd30) + 40'(r_cx));
                    r_state <= S_WY;
                end
                S_WY: begin
                    r_wy <= sat32(40'(rnd30) + 40'(r_cy));
                    r_red <= (r_ang30 + Q30_YAW_OFFSET) >>> 1;
                    r_pass <= 1'b1;
                    r_state <= S_RED;
                end
                S_QUAT: begin
                    r_qz <= clamp_one(r_sin);
                    r_qw <= clamp_one(r_cos);
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data <= {6'd0, 6'(r_n), r_qw, r_qz, r_wy, r_wx};
                        r_out_last <= is_last;
                        if (is_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_n <= r_n + 1'b1;
                            r_i <= i_plus[19:0];
                            r_state <= S_WP_MUL;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = r_out_data;
    assign m_axis_tlast = r_out_last;

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("new request taken while a request is in progress");

    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_out_valid && !m_axis_tready) |=> (r_state == S_EMIT))
        else $error("waypoint left the emit state while the output beat was stalled");

    a_offset_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (21'(r_i) < 21'(r_sweep_limit)))
        else $error("angle offset reached the sweep limit");

    a_count_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_n <= NW'(MAX_WAYPOINTS - 1)))
        else $error("waypoint count exceeded the cap");

endmodule
`default_nettype wire
